>>> src/zigzag_scan_reorder_macros.svh
// Assertion helpers shared by the zigzag reorder modules.
// The including module provides the clock and reset signals.
`ifndef ZIGZAG_SCAN_REORDER_MACROS_SVH
`define ZIGZAG_SCAN_REORDER_MACROS_SVH

// Check the consequent in the same cycle as the antecedent.
`define ZZ_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check the consequent in the cycle after the antecedent.
`define ZZ_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> src/zz_pkg.sv
`default_nettype none

package zz_pkg;

   localparam int DEF_MAX_SIDE   = 32;
   localparam int DEF_VALUE_BITS = 16;

   localparam int ELEM_W  = 16;
   localparam int CFG_W   = 6;
   // caps that cover the whole MAX_SIDE range (up to 64)
   localparam int SIDE_W  = 7;
   localparam int POS_W   = 6;
   localparam int TOTAL_W = 13;

   localparam logic [CFG_W-1:0] SIDE_RESET = 6'd8;

   localparam logic OP_LOAD = 1'b0;
   localparam logic OP_EMIT = 1'b1;

   // scan address moves
   localparam logic [2:0] STEP_HOLD      = 3'd0;
   localparam logic [2:0] STEP_RIGHT     = 3'd1;
   localparam logic [2:0] STEP_DOWN      = 3'd2;
   localparam logic [2:0] STEP_UP_RIGHT  = 3'd3;
   localparam logic [2:0] STEP_DOWN_LEFT = 3'd4;

   typedef struct packed {
      logic               op;
      logic signed [15:0] element_value;
   } req_payload_type;

   typedef struct packed {
      logic signed [15:0] element_out;
      logic               last_element;
   } rsp_payload_type;

   typedef struct packed {
      logic       load;
      logic       emit;
      logic       restart;
      logic [2:0] step;
   } cmd_type;

   typedef struct packed {
      logic [POS_W-1:0]   last_pos;
      logic [TOTAL_W-1:0] total;
      logic               load_full;
      logic               cfg_write;
   } status_type;

endpackage

`default_nettype wire

>>> src/zz_ram.sv
`default_nettype none

module zz_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  wire logic                                    clock,
   input  wire logic                                    wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                        wr_data,
   input  wire logic                                    rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> src/zz_datapath.sv
`default_nettype none

module zz_datapath #(
   parameter int MAX_SIDE   = zz_pkg::DEF_MAX_SIDE,
   parameter int VALUE_BITS = zz_pkg::DEF_VALUE_BITS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [zz_pkg::CFG_W-1:0]      csr_data,
   input  wire zz_pkg::req_payload_type       req_payload,
   input  wire zz_pkg::cmd_type               cmd,
   output zz_pkg::status_type                 status,
   output logic                               rsp_strobe,
   output zz_pkg::rsp_payload_type            rsp_payload
);

   `include "zigzag_scan_reorder_macros.svh"

   localparam int DEPTH      = MAX_SIDE * MAX_SIDE;
   localparam int ADDR_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COUNT_BITS = $clog2(DEPTH + 1);

   logic [zz_pkg::CFG_W-1:0]      side_ff;
   logic [zz_pkg::SIDE_W-1:0]     side_ext;
   logic [zz_pkg::SIDE_W-1:0]     n;
   logic [2*zz_pkg::SIDE_W-1:0]   n_sq;
   logic [zz_pkg::TOTAL_W-1:0]    total;
   logic                          cfg_write;

   logic [COUNT_BITS-1:0]         load_count_ff;
   logic [COUNT_BITS-1:0]         load_count_in;
   logic [ADDR_BITS-1:0]          addr_ff;
   logic [ADDR_BITS-1:0]          addr_in;
   logic [zz_pkg::TOTAL_W-1:0]    addr_w;
   logic [zz_pkg::TOTAL_W-1:0]    n_w;
   logic [zz_pkg::TOTAL_W-1:0]    addr_next_w;

   logic [VALUE_BITS-1:0]         wr_data;
   logic [VALUE_BITS-1:0]         rd_data;
   logic [zz_pkg::ELEM_W-1:0]     elem_out;
   logic                          rsp_valid_ff;
   logic                          rsp_last_ff;

   assign csr_ready = 1'b1;
   assign cfg_write = csr_valid & csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff <= zz_pkg::SIDE_RESET;
      end else if (cfg_write) begin
         side_ff <= csr_data;
      end
   end

   // clamp the side into 1..MAX_SIDE
   always_comb begin
      side_ext = zz_pkg::SIDE_W'(side_ff);
      if (side_ff == '0) begin
         n = zz_pkg::SIDE_W'(1);
      end else if (side_ext > zz_pkg::SIDE_W'(MAX_SIDE)) begin
         n = zz_pkg::SIDE_W'(MAX_SIDE);
      end else begin
         n = side_ext;
      end
      n_sq = n * n;
      total = n_sq[zz_pkg::TOTAL_W-1:0];
   end

   assign status.last_pos  = zz_pkg::POS_W'(n - zz_pkg::SIDE_W'(1));
   assign status.total     = total;
   assign status.load_full = zz_pkg::TOTAL_W'(load_count_ff) >= total;
   assign status.cfg_write = cfg_write;

   // scan address follows the walk without a multiply
   always_comb begin
      addr_w = zz_pkg::TOTAL_W'(addr_ff);
      n_w    = zz_pkg::TOTAL_W'(n);
      unique case (cmd.step)
         zz_pkg::STEP_HOLD:      addr_next_w = addr_w;
         zz_pkg::STEP_RIGHT:     addr_next_w = addr_w + zz_pkg::TOTAL_W'(1);
         zz_pkg::STEP_DOWN:      addr_next_w = addr_w + n_w;
         zz_pkg::STEP_UP_RIGHT:  addr_next_w = addr_w - n_w + zz_pkg::TOTAL_W'(1);
         zz_pkg::STEP_DOWN_LEFT: addr_next_w = addr_w + n_w - zz_pkg::TOTAL_W'(1);
         default:                addr_next_w = addr_w;
      endcase

      if (cfg_write || cmd.restart) begin
         addr_in       = '0;
         load_count_in = '0;
      end else begin
         addr_in       = addr_next_w[ADDR_BITS-1:0];
         load_count_in = cmd.load ? load_count_ff + COUNT_BITS'(1) : load_count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff       <= '0;
         load_count_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         addr_ff       <= addr_in;
         load_count_ff <= load_count_in;
         rsp_valid_ff  <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      rsp_last_ff <= cmd.restart;
   end

   generate
      if (VALUE_BITS >= zz_pkg::ELEM_W) begin : g_wide
         assign wr_data  = VALUE_BITS'(req_payload.element_value[zz_pkg::ELEM_W-1:0]);
         assign elem_out = rd_data[zz_pkg::ELEM_W-1:0];
      end else begin : g_narrow
         assign wr_data  = req_payload.element_value[VALUE_BITS-1:0];
         assign elem_out = zz_pkg::ELEM_W'(rd_data);
      end
   endgenerate

   zz_ram #(
      .WIDTH (VALUE_BITS),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.load),
      .wr_addr (load_count_ff[ADDR_BITS-1:0]),
      .wr_data (wr_data),
      .rd_en   (cmd.emit),
      .rd_addr (addr_ff),
      .rd_data (rd_data)
   );

   assign rsp_strobe              = rsp_valid_ff;
   assign rsp_payload.element_out = elem_out;
   assign rsp_payload.last_element = rsp_last_ff;

   `ZZ_ASSERT_NEXT(a_rsp_after_emit, cmd.emit, rsp_strobe, "emit request gave no result")
   `ZZ_ASSERT_NOW(a_load_in_range, cmd.load, !status.load_full, "load past the matrix end")

endmodule

`default_nettype wire

>>> src/zz_ctrl.sv
`default_nettype none

module zz_ctrl #(
   parameter int MAX_SIDE = zz_pkg::DEF_MAX_SIDE
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic                op,
   input  wire zz_pkg::status_type  status,
   output zz_pkg::cmd_type          cmd
);

   `include "zigzag_scan_reorder_macros.svh"

   localparam int DEPTH      = MAX_SIDE * MAX_SIDE;
   localparam int ROW_BITS   = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
   localparam int COUNT_BITS = $clog2(DEPTH + 1);

   localparam logic [1:0] DIR_UP_RIGHT  = 2'd0;
   localparam logic [1:0] DIR_DOWN_LEFT = 2'd1;

   logic [1:0]            dir_ff;
   logic [1:0]            dir_in;
   logic [ROW_BITS-1:0]   row_ff;
   logic [ROW_BITS-1:0]   row_in;
   logic [ROW_BITS-1:0]   col_ff;
   logic [ROW_BITS-1:0]   col_in;
   logic [COUNT_BITS-1:0] emit_count_ff;
   logic [COUNT_BITS-1:0] emit_count_in;

   logic                  is_emit;
   logic                  is_load;
   logic                  last;
   logic [zz_pkg::POS_W-1:0] row_w;
   logic [zz_pkg::POS_W-1:0] col_w;
   logic [2:0]            step;
   logic                  in_matrix;
   logic                  at_start;
   logic                  wrapped;

   assign is_emit = start && (op == zz_pkg::OP_EMIT);
   assign is_load = start && (op == zz_pkg::OP_LOAD) && !status.load_full;
   assign last    = (zz_pkg::TOTAL_W'(emit_count_ff) + zz_pkg::TOTAL_W'(1)) >= status.total;
   assign row_w   = zz_pkg::POS_W'(row_ff);
   assign col_w   = zz_pkg::POS_W'(col_ff);

   always_comb begin
      dir_in        = dir_ff;
      row_in        = row_ff;
      col_in        = col_ff;
      emit_count_in = emit_count_ff;
      step          = zz_pkg::STEP_HOLD;

      if (status.cfg_write || (is_emit && last)) begin
         dir_in        = DIR_UP_RIGHT;
         row_in        = '0;
         col_in        = '0;
         emit_count_in = '0;
      end else if (is_emit) begin
         emit_count_in = emit_count_ff + COUNT_BITS'(1);
         unique case (dir_ff)
            DIR_UP_RIGHT: begin
               if (col_w >= status.last_pos) begin
                  row_in = row_ff + ROW_BITS'(1);
                  dir_in = DIR_DOWN_LEFT;
                  step   = zz_pkg::STEP_DOWN;
               end else if (row_ff == '0) begin
                  col_in = col_ff + ROW_BITS'(1);
                  dir_in = DIR_DOWN_LEFT;
                  step   = zz_pkg::STEP_RIGHT;
               end else begin
                  row_in = row_ff - ROW_BITS'(1);
                  col_in = col_ff + ROW_BITS'(1);
                  step   = zz_pkg::STEP_UP_RIGHT;
               end
            end
            DIR_DOWN_LEFT: begin
               if (row_w >= status.last_pos) begin
                  col_in = col_ff + ROW_BITS'(1);
                  dir_in = DIR_UP_RIGHT;
                  step   = zz_pkg::STEP_RIGHT;
               end else if (col_ff == '0) begin
                  row_in = row_ff + ROW_BITS'(1);
                  dir_in = DIR_UP_RIGHT;
                  step   = zz_pkg::STEP_DOWN;
               end else begin
                  row_in = row_ff + ROW_BITS'(1);
                  col_in = col_ff - ROW_BITS'(1);
                  step   = zz_pkg::STEP_DOWN_LEFT;
               end
            end
            default: begin
               dir_in = DIR_UP_RIGHT;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff        <= DIR_UP_RIGHT;
         row_ff        <= '0;
         col_ff        <= '0;
         emit_count_ff <= '0;
      end else begin
         dir_ff        <= dir_in;
         row_ff        <= row_in;
         col_ff        <= col_in;
         emit_count_ff <= emit_count_in;
      end
   end

   assign cmd.load    = is_load;
   assign cmd.emit    = is_emit;
   assign cmd.restart = is_emit && last;
   assign cmd.step    = step;

   assign in_matrix = (row_w <= status.last_pos) && (col_w <= status.last_pos);
   assign at_start  = (row_ff == '0) && (col_ff == '0) && (emit_count_ff == '0)
                      && (dir_ff == DIR_UP_RIGHT);
   assign wrapped   = cmd.restart && !status.cfg_write;

   `ZZ_ASSERT_NOW(a_one_access, 1'b1, !(cmd.load && cmd.emit), "load and emit in one cycle")
   `ZZ_ASSERT_NOW(a_pos_in_matrix, 1'b1, in_matrix, "scan left the matrix")
   `ZZ_ASSERT_NEXT(a_wrap_to_start, wrapped, at_start, "scan did not return to start")

endmodule

`default_nettype wire

>>> src/zigzag_scan_reorder.sv
// Channel    Ports                                   Transfer
// request    start, busy, req_payload                start high, busy low
// result     rsp_strobe, rsp_payload                 one cycle per strobe
// csr        csr_valid, csr_ready, csr_data          valid and ready high
//
// One request is taken each cycle; busy stays low.
// A load writes the element store in the cycle it is taken.
// An emit result appears in the cycle after the request, set by the store's read register.
// Synchronous active-high reset returns the side to 8 and the scan to the top-left corner.
// The receiver cannot stall results; each strobe lasts exactly one cycle.
`default_nettype none

module zigzag_scan_reorder #(
   parameter int MAX_SIDE   = zz_pkg::DEF_MAX_SIDE,
   parameter int VALUE_BITS = zz_pkg::DEF_VALUE_BITS
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output logic                            busy,
   input  wire zz_pkg::req_payload_type    req_payload,
   output logic                            rsp_strobe,
   output zz_pkg::rsp_payload_type         rsp_payload,
   input  wire logic                       csr_valid,
   output logic                            csr_ready,
   input  wire logic [zz_pkg::CFG_W-1:0]   csr_data
);

   zz_pkg::cmd_type    cmd;
   zz_pkg::status_type status;

   assign busy = 1'b0;

   zz_ctrl #(
      .MAX_SIDE (MAX_SIDE)
   ) u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .op     (req_payload.op),
      .status (status),
      .cmd    (cmd)
   );

   zz_datapath #(
      .MAX_SIDE   (MAX_SIDE),
      .VALUE_BITS (VALUE_BITS)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data),
      .req_payload (req_payload),
      .cmd         (cmd),
      .status      (status),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

>>> tb/tb_zigzag_scan_reorder.sv
`default_nettype none

module tb_zigzag_scan_reorder;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_SIDE   = zz_pkg::DEF_MAX_SIDE;
   localparam int MAX_CELLS  = MAX_SIDE * MAX_SIDE;
   localparam int PLAN_LEN   = 13;
   localparam int CYCLE_CAP  = 200000;
   localparam int DRAIN_WAIT = 8;
   localparam int SIDE_PLAN [PLAN_LEN] = '{3, 8, 1, 5, 63, 2, 7, 4, 33, 6, 16, 0, 32};

   typedef enum bit {SCAN_UP_RIGHT, SCAN_DOWN_LEFT} scan_dir_type;

   class zigzag_tracker;
      logic [zz_pkg::ELEM_W-1:0] cells [MAX_CELLS];
      bit                        written [MAX_CELLS];
      int unsigned               loaded;
      int unsigned               emitted;
      int unsigned               row;
      int unsigned               col;
      scan_dir_type              dir;
      logic [zz_pkg::CFG_W-1:0]  side;
      zz_pkg::rsp_payload_type   pending_elements [$];
      int                        errors;

      function new();
         side   = zz_pkg::SIDE_RESET;
         errors = 0;
         restart();
      endfunction

      function int unsigned span();
         if (side == 0) return 1;
         if (side > MAX_SIDE) return MAX_SIDE;
         return side;
      endfunction

      function void restart();
         loaded  = 0;
         emitted = 0;
         row     = 0;
         col     = 0;
         dir     = SCAN_UP_RIGHT;
      endfunction

      function void set_side(logic [zz_pkg::CFG_W-1:0] v);
         side = v;
         restart();
      endfunction

      function bit load_full();
         return loaded >= span() * span();
      endfunction

      function bit emit_ready();
         return written[row * span() + col];
      endfunction

      function void step_scan(int unsigned n);
         if (dir == SCAN_UP_RIGHT) begin
            if (col >= n - 1) begin
               row++;
               dir = SCAN_DOWN_LEFT;
            end else if (row == 0) begin
               col++;
               dir = SCAN_DOWN_LEFT;
            end else begin
               row--;
               col++;
            end
         end else begin
            if (row >= n - 1) begin
               col++;
               dir = SCAN_UP_RIGHT;
            end else if (col == 0) begin
               row++;
               dir = SCAN_UP_RIGHT;
            end else begin
               row++;
               col--;
            end
         end
      endfunction

      function void note_request(zz_pkg::req_payload_type r);
         int unsigned             n;
         int unsigned             total;
         zz_pkg::rsp_payload_type exp;
         n     = span();
         total = n * n;
         if (r.op == zz_pkg::OP_LOAD) begin
            // drop loads past the end of the matrix
            if (loaded < total) begin
               cells[loaded]   = r.element_value;
               written[loaded] = 1'b1;
               loaded++;
            end
         end else begin
            exp.element_out  = cells[row * n + col];
            exp.last_element = (emitted + 1 >= total);
            pending_elements.push_back(exp);
            if (exp.last_element) begin
               restart();
            end else begin
               emitted++;
               step_scan(n);
            end
         end
      endfunction

      function void check_element(zz_pkg::rsp_payload_type got);
         zz_pkg::rsp_payload_type exp;
         if (pending_elements.size() == 0) begin
            errors++;
            $display("%0t: unexpected element: expected none, actual %h/%0b",
                     $time, got.element_out, got.last_element);
            return;
         end
         exp = pending_elements.pop_front();
         if (got.element_out !== exp.element_out) begin
            errors++;
            $display("%0t: element_out mismatch: expected %h, actual %h",
                     $time, exp.element_out, got.element_out);
         end
         if (got.last_element !== exp.last_element) begin
            errors++;
            $display("%0t: last_element mismatch: expected %0b, actual %0b",
                     $time, exp.last_element, got.last_element);
         end
      endfunction
   endclass

   logic                     clock       = 1'b0;
   logic                     reset       = 1'b1;
   logic                     start       = 1'b0;
   logic                     busy;
   zz_pkg::req_payload_type  req_payload = '0;
   logic                     rsp_strobe;
   zz_pkg::rsp_payload_type  rsp_payload;
   logic                     csr_valid   = 1'b0;
   logic                     csr_ready;
   logic [zz_pkg::CFG_W-1:0] csr_data    = '0;

   zigzag_tracker tracker = new();
   int            cycles  = 0;

   zigzag_scan_reorder DUT (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_payload (req_payload),
      .rsp_strobe  (rsp_strobe),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_data    (csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_CAP) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) tracker.check_element(rsp_payload);
         if (start && !busy) tracker.note_request(req_payload);
         if (csr_valid && csr_ready) tracker.set_side(csr_data);
      end
   end

   function automatic zz_pkg::req_payload_type make_request();
      zz_pkg::req_payload_type r;
      if ($urandom_range(0, 7) == 0) begin
         case ($urandom_range(0, 3))
            0: r.element_value = 16'sh8000;
            1: r.element_value = 16'sh7fff;
            2: r.element_value = 16'sh0000;
            default: r.element_value = 16'shffff;
         endcase
      end else begin
         r.element_value = 16'($urandom());
      end
      // emit only where the store already holds data
      if (tracker.load_full())
         r.op = ($urandom_range(0, 99) < 10) ? zz_pkg::OP_LOAD : zz_pkg::OP_EMIT;
      else if (tracker.emit_ready() && $urandom_range(0, 99) < 35)
         r.op = zz_pkg::OP_EMIT;
      else
         r.op = zz_pkg::OP_LOAD;
      return r;
   endfunction

   // call right after a falling edge; hold the request until taken
   task automatic drive(zz_pkg::req_payload_type r);
      start       <= 1'b1;
      req_payload <= r;
      do @(posedge clock); while (busy);
   endtask

   task automatic fixed_request(logic op, logic signed [15:0] value);
      zz_pkg::req_payload_type r;
      r.op            = op;
      r.element_value = value;
      @(negedge clock);
      drive(r);
   endtask

   task automatic random_request(int idle_pct, output bit counted);
      zz_pkg::req_payload_type r;
      while ($urandom_range(0, 99) < idle_pct) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      r       = make_request();
      counted = !(r.op == zz_pkg::OP_LOAD && tracker.load_full());
      drive(r);
   endtask

   task automatic wait_idle();
      @(negedge clock);
      start <= 1'b0;
      while (tracker.pending_elements.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic write_side(logic [zz_pkg::CFG_W-1:0] v);
      wait_idle();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data  <= v;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   initial begin
      int budget;
      int idle_pct;
      int done;
      bit counted;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset side, partial matrix with extreme values
      fixed_request(zz_pkg::OP_LOAD, 16'sh8000);
      fixed_request(zz_pkg::OP_LOAD, 16'sh7fff);
      fixed_request(zz_pkg::OP_LOAD, 16'sh0000);
      fixed_request(zz_pkg::OP_EMIT, 16'sh0000);
      fixed_request(zz_pkg::OP_EMIT, 16'sh0000);
      // zero side acts as one; extra load dropped; emit after wrap reads old data
      write_side(6'd0);
      fixed_request(zz_pkg::OP_LOAD, 16'shffff);
      fixed_request(zz_pkg::OP_LOAD, 16'sh1234);
      fixed_request(zz_pkg::OP_EMIT, 16'sh0000);
      fixed_request(zz_pkg::OP_EMIT, 16'sh0000);
      write_side(6'd2);
      fixed_request(zz_pkg::OP_LOAD, 16'sh0005);
      fixed_request(zz_pkg::OP_LOAD, 16'sh0006);
      fixed_request(zz_pkg::OP_LOAD, 16'sh0007);
      fixed_request(zz_pkg::OP_LOAD, 16'sh0008);
      fixed_request(zz_pkg::OP_LOAD, 16'sh2222);
      repeat (4) fixed_request(zz_pkg::OP_EMIT, 16'sh0000);
      // oversize side clamps to the maximum
      write_side(6'd40);
      fixed_request(zz_pkg::OP_EMIT, 16'sh0000);
      fixed_request(zz_pkg::OP_LOAD, 16'sh5555);
      fixed_request(zz_pkg::OP_EMIT, 16'sh0000);

      for (int k = 0; k < PLAN_LEN; k++) begin
         write_side(zz_pkg::CFG_W'(SIDE_PLAN[k]));
         idle_pct = (k < 4) ? 24 : (k < 8) ? 78 : 0;
         // the last phase runs a longer stretch at the maximum side
         budget = (k == PLAN_LEN - 1) ? 600 : 60;
         done   = 0;
         while (done < budget) begin
            random_request(idle_pct, counted);
            if (counted) done++;
         end
      end

      wait_idle();
      repeat (DRAIN_WAIT) @(posedge clock);
      if (tracker.errors == 0 && tracker.pending_elements.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

`default_nettype wire

>>> zigzag_scan_reorder.f
+incdir+src
src/zz_pkg.sv
src/zz_ram.sv
src/zz_datapath.sv
src/zz_ctrl.sv
src/zigzag_scan_reorder.sv
tb/tb_zigzag_scan_reorder.sv
